// ===== hdl/fsp_pkg.sv =====
// Shared types and constants for the flux stream parser.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package fsp_pkg;

  // Stream code bytes
  localparam logic [7:0] CODE_I2_MAX = 8'h07;  // highest two-byte interval code
  localparam logic [7:0] CODE_NOP1   = 8'h08;
  localparam logic [7:0] CODE_NOP2   = 8'h09;
  localparam logic [7:0] CODE_NOP3   = 8'h0A;
  localparam logic [7:0] CODE_OVF    = 8'h0B;
  localparam logic [7:0] CODE_V16    = 8'h0C;
  localparam logic [7:0] CODE_OOB    = 8'h0D;

  localparam logic [31:0] OVF_ADD = 32'h0001_0000;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_I2_LO    = 4'd1,
    PH_SKIP1    = 4'd2,
    PH_SKIP2    = 4'd3,
    PH_V16_LO   = 4'd4,
    PH_V16_HI   = 4'd5,
    PH_OOB_TYPE = 4'd6,
    PH_OOB_LLO  = 4'd7,
    PH_OOB_LHI  = 4'd8,
    PH_OOB_DATA = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FLUX     = 2'd0,
    KIND_OOB_HDR  = 2'd1,
    KIND_OOB_DATA = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] flux;
    logic [7:0]  oob_type;
    logic [15:0] oob_length;
    logic [7:0]  payload;
    logic [31:0] offset;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/fsp_core.sv =====
// Parse state and single-pass decode of one stream byte per step.
// Depends on fsp_pkg for phase codes, code bytes and the result struct.
`default_nettype none

module fsp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      code,
  output logic                 res_valid,
  output fsp_pkg::result_t     res
);
  import fsp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] interval_sum, interval_sum_next;
  logic [7:0]  block_type, block_type_next;
  logic [15:0] block_length, block_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] event_start, event_start_next;

  logic [31:0] addend;
  logic [31:0] sum_added;
  logic [15:0] hdr_length;
  logic [15:0] rem_dec;

  // Pick the one value this byte adds to the running interval.
  always_comb begin
    addend = '0;
    unique case (phase)
      PH_I2_LO, PH_V16_LO: addend = {24'd0, code};
      PH_V16_HI:           addend = {16'd0, code, 8'd0};
      PH_SKIP1, PH_SKIP2, PH_OOB_TYPE, PH_OOB_LLO, PH_OOB_LHI, PH_OOB_DATA:
        addend = '0;
      default: begin
        priority if (code <= CODE_I2_MAX) addend = {16'd0, code, 8'd0};
        else if (code == CODE_OVF)         addend = OVF_ADD;
        else if (code == CODE_NOP1 || code == CODE_NOP2 || code == CODE_NOP3 ||
                 code == CODE_V16 || code == CODE_OOB)
          addend = '0;
        else                               addend = {24'd0, code};
      end
    endcase
  end

  assign sum_added          = interval_sum + addend;
  assign byte_position_next = byte_position + 32'd1;
  assign hdr_length         = {code, block_length[7:0]};
  assign rem_dec            = bytes_remaining - 16'd1;

  always_comb begin
    phase_next           = phase;
    interval_sum_next    = sum_added;
    block_type_next      = block_type;
    block_length_next    = block_length;
    bytes_remaining_next = bytes_remaining;
    event_start_next     = event_start;
    res_valid            = 1'b0;
    res.kind             = KIND_FLUX;
    res.flux             = sum_added;
    res.oob_type         = '0;
    res.oob_length       = '0;
    res.payload          = '0;
    res.offset           = event_start;
    res.last             = 1'b1;
    unique case (phase)
      PH_I2_LO, PH_V16_HI: begin
        res_valid         = 1'b1;
        phase_next        = PH_IDLE;
        interval_sum_next = '0;
        event_start_next  = byte_position_next;
      end
      PH_SKIP1:   phase_next = PH_IDLE;
      PH_SKIP2:   phase_next = PH_SKIP1;
      PH_V16_LO:  phase_next = PH_V16_HI;
      PH_OOB_TYPE: begin
        block_type_next = code;
        phase_next      = PH_OOB_LLO;
      end
      PH_OOB_LLO: begin
        block_length_next = {8'd0, code};
        phase_next        = PH_OOB_LHI;
      end
      PH_OOB_LHI: begin
        block_length_next    = hdr_length;
        bytes_remaining_next = hdr_length;
        res_valid            = 1'b1;
        res.kind             = KIND_OOB_HDR;
        res.flux             = interval_sum;
        res.oob_type         = block_type;
        res.oob_length       = hdr_length;
        res.last             = (hdr_length == 16'd0);
        if (hdr_length == 16'd0) begin
          phase_next        = PH_IDLE;
          interval_sum_next = '0;
          event_start_next  = byte_position_next;
        end else begin
          phase_next = PH_OOB_DATA;
        end
      end
      PH_OOB_DATA: begin
        bytes_remaining_next = rem_dec;
        res_valid            = 1'b1;
        res.kind             = KIND_OOB_DATA;
        res.flux             = interval_sum;
        res.oob_type         = block_type;
        res.oob_length       = block_length;
        res.payload          = code;
        res.last             = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) begin
          phase_next        = PH_IDLE;
          interval_sum_next = '0;
          event_start_next  = byte_position_next;
        end
      end
      default: begin
        // idle, and any phase code outside the defined set
        priority if (code <= CODE_I2_MAX) phase_next = PH_I2_LO;
        else if (code == CODE_NOP1)        phase_next = PH_IDLE;
        else if (code == CODE_NOP2)        phase_next = PH_SKIP1;
        else if (code == CODE_NOP3)        phase_next = PH_SKIP2;
        else if (code == CODE_OVF)         phase_next = PH_IDLE;
        else if (code == CODE_V16)         phase_next = PH_V16_LO;
        else if (code == CODE_OOB)         phase_next = PH_OOB_TYPE;
        else begin
          res_valid         = 1'b1;
          phase_next        = PH_IDLE;
          interval_sum_next = '0;
          event_start_next  = byte_position_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      interval_sum    <= '0;
      block_type      <= '0;
      block_length    <= '0;
      bytes_remaining <= '0;
      byte_position   <= '0;
      event_start     <= '0;
    end else if (step) begin
      phase           <= phase_next;
      interval_sum    <= interval_sum_next;
      block_type      <= block_type_next;
      block_length    <= block_length_next;
      bytes_remaining <= bytes_remaining_next;
      byte_position   <= byte_position_next;
      event_start     <= event_start_next;
    end
  end

  a_flux_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_FLUX) |-> res.last)
    else $error("flux result without last mark");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    step |=> byte_position == $past(byte_position) + 32'd1)
    else $error("byte position did not advance by one");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(byte_position) && $stable(phase))
    else $error("parse state moved without a step");

  a_event_close: assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && res.last) |=>
      (event_start == byte_position) && (interval_sum == 32'd0) && (phase == PH_IDLE))
    else $error("event did not close cleanly");

endmodule

`default_nettype wire

// ===== hdl/fsp_out_stage.sv =====
// Result register of the flux stream parser; holds a result while the sink stalls.
// Depends on fsp_pkg for the result struct.
`default_nettype none

module fsp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire fsp_pkg::result_t load_res,
  input  wire logic             stall,
  output logic                  valid,
  output logic                  free,
  output fsp_pkg::result_t      res
);
  import fsp_pkg::*;

  // Free when empty or when the held transaction leaves this cycle.
  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> valid && $stable(res))
    else $error("stalled result changed");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded over a waiting transaction");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== hdl/flux_stream_parser_top.sv =====
// Top level of the flux stream parser: input register, parse core, result register.
// Depends on fsp_pkg, fsp_core and fsp_out_stage.
//
// Usage:
//   Input channel (stream_valid / stream_stall / stream_byte) carries one raw
//   flux stream byte per transaction. Output channel (event_valid /
//   event_stall and the event fields) carries flux events, out-of-band block
//   headers and out-of-band payload bytes, each with a last mark on the final
//   transaction of its event.
//   Throughput: one stream byte per clock while the input channel is not
//   stalled. A byte goes into the input register, is decoded by the core in
//   the following cycle and, if it completes something, lands in the result
//   register, from which it is presented.
//   Bytes that produce no result (code bytes, skipped bytes, type bytes, low length bytes)
//   pass through the core without using the output channel.
//   While the sink stalls, the result register holds its transaction; the
//   held input byte waits only if it would produce a result, and the input
//   channel stalls only when that held byte cannot move.
//   Reset clears the parse state, byte position and event start to zero and
//   empties both registers. An unfinished event at the end of a stream
//   simply never produces its result.
`default_nettype none

module flux_stream_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        stream_valid,
  output logic             stream_stall,
  input  wire logic [7:0]  stream_byte,
  output logic             event_valid,
  input  wire logic        event_stall,
  output logic [1:0]       event_kind,
  output logic [31:0]      flux_value,
  output logic [7:0]       oob_type,
  output logic [15:0]      oob_length,
  output logic [7:0]       payload_byte,
  output logic [31:0]      event_offset,
  output logic             last
);
  import fsp_pkg::*;

  logic    hold_valid;
  logic [7:0] hold_byte;
  logic    core_res_valid;
  result_t core_res;
  logic    out_free;
  logic    advance;
  result_t out_res;

  // Advance the held byte unless it needs the result register and that is busy.
  assign advance      = hold_valid && (!core_res_valid || out_free);
  assign stream_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!stream_stall) begin
      hold_valid <= stream_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stream_stall && stream_valid) begin
      hold_byte <= stream_byte;
    end
  end

  fsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .code      (hold_byte),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  fsp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && core_res_valid),
    .load_res (core_res),
    .stall    (event_stall),
    .valid    (event_valid),
    .free     (out_free),
    .res      (out_res)
  );

  assign event_kind   = out_res.kind;
  assign flux_value   = out_res.flux;
  assign oob_type     = out_res.oob_type;
  assign oob_length   = out_res.oob_length;
  assign payload_byte = out_res.payload;
  assign event_offset = out_res.offset;
  assign last         = out_res.last;

  a_stall_only_held: assert property (@(posedge clk) disable iff (rst)
    stream_stall |-> hold_valid && core_res_valid && event_valid)
    else $error("input stalled without a blocked result");

  a_held_byte_stays: assert property (@(posedge clk) disable iff (rst)
    stream_stall |=> hold_valid && $stable(hold_byte))
    else $error("held stream byte lost while stalled");

  a_kind_defined: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (event_kind == KIND_FLUX || event_kind == KIND_OOB_HDR ||
                     event_kind == KIND_OOB_DATA))
    else $error("undefined event kind presented");

endmodule

`default_nettype wire
